// ===== sv/ird_pkg.sv =====
`timescale 1ns / 1ps

package ird_pkg;

  // Field widths on the channels
  localparam int SAMPLE_W   = 16;
  localparam int CH_W       = 3;
  localparam int DIST_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Register indexes on the configuration channel
  localparam logic [CFG_IDX_W-1:0] REG_FRONT_THR = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_THR  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_THR = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FRONT_CH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_CH   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_CH  = 3'd5;

  localparam logic [DIST_W-1:0] THR_RESET      = 16'd1600;
  localparam logic [CH_W-1:0]   FRONT_CH_RESET = 3'd0;
  localparam logic [CH_W-1:0]   LEFT_CH_RESET  = 3'd1;
  localparam logic [CH_W-1:0]   RIGHT_CH_RESET = 3'd2;

  // Horner accumulator: 1/16 mm with 16 fraction bits, all partial sums fit in 36 bits
  localparam int ACC_W     = 36;
  localparam int FRAC_BITS = 16;
  localparam int ROUND_HALF = 32768;

  // 160 * a_k * 3.3^k * 2^16, rounded half up
  localparam longint C0 = longint'((64'd160 * 64'd339 * 64'd65536 + 64'd5) / 64'd10);
  localparam longint C1 =
    longint'((64'd160 * 64'd695 * 64'd33 * 64'd65536 + 64'd50) / 64'd100);
  localparam longint C2 =
    longint'((64'd160 * 64'd623 * 64'd1089 * 64'd65536 + 64'd500) / 64'd1000);
  localparam longint C3 =
    longint'((64'd160 * 64'd254 * 64'd35937 * 64'd65536 + 64'd5000) / 64'd10000);
  localparam longint C4 =
    longint'((64'd160 * 64'd383 * 64'd1185921 * 64'd65536 + 64'd500000) / 64'd1000000);

  localparam logic signed [ACC_W-1:0] HORNER_START = ACC_W'(C4);

  // Constant added after each multiply pass, signs folded in
  function automatic logic signed [ACC_W-1:0] horner_coef(logic [1:0] step);
    logic signed [ACC_W-1:0] c;
    case (step)
      2'd0:    c = ACC_W'(-C3);
      2'd1:    c = ACC_W'(C2);
      2'd2:    c = ACC_W'(-C1);
      default: c = ACC_W'(C0);
    endcase
    return c;
  endfunction

  // Power-law table arithmetic, evaluated at elaboration only
  localparam int QL = 28;
  localparam int QE = 30;
  localparam longint unsigned LN2_Q30 = 64'd744261118;

  // log2(n) in Q28, fraction bits by repeated squaring of a Q30 mantissa
  function automatic longint log2_q(longint unsigned n);
    int unsigned p;
    longint unsigned x;
    longint unsigned frac;
    p = 0;
    frac = 64'd0;
    for (int i = 0; i < 30; i++) begin
      if ((n >> (p + 1)) != 64'd0) p++;
    end
    x = n << (30 - p);
    for (int i = 0; i < QL; i++) begin
      x = (x * x) >> QE;
      frac = frac << 1;
      if (x >= (64'd1 << 31)) begin
        x = x >> 1;
        frac = frac | 64'd1;
      end
    end
    return longint'((64'(p) << QL) | frac);
  endfunction

  // 1932.8 * v^-1.058 at the midpoint of bin, with e index bits
  function automatic logic [DIST_W-1:0] power_entry(longint unsigned bin, int unsigned e);
    longint unsigned m;
    longint unsigned f;
    longint unsigned t;
    longint unsigned term;
    longint unsigned sum;
    longint unsigned v;
    longint lg10;
    longint lv;
    longint y;
    longint z;
    longint k;
    int unsigned shift;
    m = 64'd2 * bin + 64'd1;
    lg10 = log2_q(64'd10);
    lv = log2_q(64'd33 * m) - lg10 - (longint'(e + 1) <<< QL);
    y = -(lv * 64'sd1058) / 64'sd1000;
    z = log2_q(64'd19328) - lg10 + y;
    k = z >>> QL;
    f = 64'(z - (k <<< QL));
    t = (f * LN2_Q30) >> QL;
    term = 64'd1 << QE;
    sum = term;
    term = ((term * t) >> QE) / 1;  sum = sum + term;
    term = ((term * t) >> QE) / 2;  sum = sum + term;
    term = ((term * t) >> QE) / 3;  sum = sum + term;
    term = ((term * t) >> QE) / 4;  sum = sum + term;
    term = ((term * t) >> QE) / 5;  sum = sum + term;
    term = ((term * t) >> QE) / 6;  sum = sum + term;
    term = ((term * t) >> QE) / 7;  sum = sum + term;
    term = ((term * t) >> QE) / 8;  sum = sum + term;
    term = ((term * t) >> QE) / 9;  sum = sum + term;
    term = ((term * t) >> QE) / 10; sum = sum + term;
    term = ((term * t) >> QE) / 11; sum = sum + term;
    term = ((term * t) >> QE) / 12; sum = sum + term;
    term = ((term * t) >> QE) / 13; sum = sum + term;
    term = ((term * t) >> QE) / 14; sum = sum + term;
    if (k >= 64'sd16) return 16'hFFFF;
    if (k < -64'sd31) return 16'h0000;
    shift = 32'(longint'(QE) - k);
    v = (sum + (64'd1 << (shift - 1))) >> shift;
    if (v > 64'd65535) return 16'hFFFF;
    return v[DIST_W-1:0];
  endfunction

endpackage

// ===== sv/ird_sample_if.sv =====
`timescale 1ns / 1ps

interface ird_sample_if import ird_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] adc_sample;

  modport source (output valid, output adc_sample, input ready);
  modport sink (input valid, input adc_sample, output ready);
endinterface

// ===== sv/ird_result_if.sv =====
`timescale 1ns / 1ps

interface ird_result_if import ird_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CH_W-1:0]   channel;
  logic [DIST_W-1:0] distance;
  logic              front_wall;
  logic              left_wall;
  logic              right_wall;

  modport source (output valid, output channel, output distance, output front_wall,
                  output left_wall, output right_wall, input ready);
  modport sink (input valid, input channel, input distance, input front_wall,
                input left_wall, input right_wall, output ready);
endinterface

// ===== sv/ird_cfg_if.sv =====
`timescale 1ns / 1ps

interface ird_cfg_if import ird_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== sv/ird_power_rom.sv =====
`timescale 1ns / 1ps

module ird_power_rom import ird_pkg::*; #(
  parameter int ADDR_W = 10
) (
  input  logic              clk,
  input  logic [ADDR_W-1:0] addr,
  output logic [DIST_W-1:0] data
);

  localparam int DEPTH = 1 << ADDR_W;

  typedef logic [DIST_W-1:0] rom_t [DEPTH];

  function automatic rom_t build_rom();
    rom_t r;
    for (int b = 0; b < DEPTH; b++) begin
      r[b] = power_entry(64'(b), 32'(ADDR_W));
    end
    return r;
  endfunction

  localparam rom_t POWER_LUT = build_rom();

  always_ff @(posedge clk) begin
    data <= POWER_LUT[addr];
  end

endmodule

// ===== sv/ird_poly_unit.sv =====
`timescale 1ns / 1ps

module ird_poly_unit import ird_pkg::*; #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [SAMPLE_BITS-1:0] x,
  output logic                   done,
  output logic [DIST_W-1:0]      distance
);

  localparam int PROD_W = ACC_W + SAMPLE_BITS + 1;

  typedef enum logic [1:0] {P_IDLE, P_MUL, P_ADD, P_FIN} state_t;

  state_t                    state;
  logic [1:0]                step;
  logic signed [ACC_W-1:0]   acc;
  logic signed [PROD_W-1:0]  prod;
  logic signed [PROD_W-1:0]  prod_sh;
  logic signed [ACC_W-1:0]   rounded;
  logic signed [ACC_W-1:0]   scaled;
  logic [DIST_W-1:0]         sat_dist;

  // floor division by 2^SAMPLE_BITS
  assign prod_sh = prod >>> SAMPLE_BITS;
  assign rounded = acc + ACC_W'(ROUND_HALF);
  assign scaled  = rounded >>> FRAC_BITS;

  always_comb begin
    if (scaled < 0) begin
      sat_dist = '0;
    end else if (scaled > ACC_W'(65535)) begin
      sat_dist = '1;
    end else begin
      sat_dist = scaled[DIST_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= P_IDLE;
      step  <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        P_IDLE: begin
          if (start) begin
            acc   <= HORNER_START;
            step  <= '0;
            state <= P_MUL;
          end
        end
        P_MUL: begin
          prod  <= acc * $signed({1'b0, x});
          state <= P_ADD;
        end
        P_ADD: begin
          acc <= $signed(prod_sh[ACC_W-1:0]) + horner_coef(step);
          if (step == 2'd3) begin
            state <= P_FIN;
          end else begin
            step  <= step + 2'd1;
            state <= P_MUL;
          end
        end
        P_FIN: begin
          distance <= sat_dist;
          done     <= 1'b1;
          state    <= P_IDLE;
        end
        default: state <= P_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/ir_distance_linearizer.sv =====
`timescale 1ns / 1ps

// IR distance linearizer. Each sample beat belongs to the next channel of a round-robin
// starting at channel 0 after reset; the result beat carries that channel, its distance
// in 1/16 mm (rounded, saturated to 0..65535) and the front, left and right wall flags,
// each set when the last distance stored for the chosen channel is below its threshold
// (a channel number beyond the channel count gives a clear flag). Channel 0 reads a
// power-law table with one entry per bin of the top ROM index bits, filled at
// elaboration, so no clearing pass follows reset. Channels 1 and up run a quartic
// Horner evaluation through a single multiplier, four multiply and add passes. One
// sample is in work at a time: a channel 0 sample goes through the ROM read, the store
// write, three flag reads through the single read port of the distance store and the
// output state; other channels run the four Horner passes in place of the ROM read. A
// finished result waits in the output register while the next sample is accepted.
module ir_distance_linearizer import ird_pkg::*; #(
  parameter int NUM_CHANNELS   = 7,
  parameter int SAMPLE_BITS    = 16,
  parameter int ROM_INDEX_BITS = 10
) (
  input  logic          clk,
  input  logic          rst,
  ird_sample_if.sink    samples,
  ird_result_if.source  results,
  ird_cfg_if.sink       cfg
);

  localparam int CNT_W  = $clog2(NUM_CHANNELS);
  localparam int ROM_AW = (ROM_INDEX_BITS < SAMPLE_BITS) ? ROM_INDEX_BITS : SAMPLE_BITS;
  localparam logic [CNT_W-1:0] LAST_CH = CNT_W'(NUM_CHANNELS - 1);
  localparam logic [4:0]       NUM_CH5 = 5'(NUM_CHANNELS);

  typedef enum logic [2:0] {
    S_IDLE, S_ROM, S_POLY, S_WRITE, S_RD_FRONT, S_RD_LEFT, S_RD_RIGHT, S_OUT
  } state_t;

  state_t                   state;
  logic [CNT_W-1:0]         counter;
  logic [CNT_W-1:0]         cur_ch;
  logic [SAMPLE_BITS-1:0]   x_q;
  logic                     poly_start;
  logic                     poly_done;
  logic [DIST_W-1:0]        poly_dist;
  logic [DIST_W-1:0]        rom_data;
  logic [ROM_AW-1:0]        rom_addr;
  logic [DIST_W-1:0]        new_dist;
  logic [DIST_W-1:0]        dist_q;

  logic [DIST_W-1:0]        dist_mem [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0]  dist_vld;
  logic                     rd_en;
  logic [CH_W-1:0]          rd_ch;
  logic [CNT_W-1:0]         rd_idx;
  logic [DIST_W-1:0]        rd_q;
  logic                     front_f;
  logic                     left_f;

  logic [DIST_W-1:0]        front_thr;
  logic [DIST_W-1:0]        left_thr;
  logic [DIST_W-1:0]        right_thr;
  logic [CH_W-1:0]          front_ch;
  logic [CH_W-1:0]          left_ch;
  logic [CH_W-1:0]          right_ch;

  logic                     res_valid;
  logic [CH_W-1:0]          res_channel;
  logic [DIST_W-1:0]        res_distance;
  logic                     res_front;
  logic                     res_left;
  logic                     res_right;

  function automatic logic ch_ok(logic [CH_W-1:0] ch);
    return 5'(ch) < NUM_CH5;
  endfunction

  ird_power_rom #(
    .ADDR_W (ROM_AW)
  ) u_power_rom (
    .clk  (clk),
    .addr (rom_addr),
    .data (rom_data)
  );

  ird_poly_unit #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_poly_unit (
    .clk      (clk),
    .rst      (rst),
    .start    (poly_start),
    .x        (x_q),
    .done     (poly_done),
    .distance (poly_dist)
  );

  assign rom_addr = x_q[SAMPLE_BITS-1 -: ROM_AW];
  assign new_dist = (cur_ch == '0) ? rom_data : poly_dist;

  // one read port on the distance store, stepped over the three wall channels
  always_comb begin
    rd_en = 1'b0;
    rd_ch = front_ch;
    unique case (state)
      S_RD_FRONT: begin rd_en = 1'b1; rd_ch = front_ch; end
      S_RD_LEFT:  begin rd_en = 1'b1; rd_ch = left_ch;  end
      S_RD_RIGHT: begin rd_en = 1'b1; rd_ch = right_ch; end
      default:    begin rd_en = 1'b0; rd_ch = front_ch; end
    endcase
  end

  assign rd_idx = CNT_W'(rd_ch);

  always_ff @(posedge clk) begin
    if (state == S_WRITE) dist_mem[cur_ch] <= new_dist;
    if (rd_en) begin
      // a channel never converted reads as zero
      rd_q <= (ch_ok(rd_ch) && dist_vld[rd_idx]) ? dist_mem[rd_idx] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dist_vld <= '0;
    end else if (state == S_WRITE) begin
      dist_vld[cur_ch] <= 1'b1;
    end
  end

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      front_thr <= THR_RESET;
      left_thr  <= THR_RESET;
      right_thr <= THR_RESET;
      front_ch  <= FRONT_CH_RESET;
      left_ch   <= LEFT_CH_RESET;
      right_ch  <= RIGHT_CH_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_FRONT_THR: front_thr <= cfg.data;
        REG_LEFT_THR:  left_thr  <= cfg.data;
        REG_RIGHT_THR: right_thr <= cfg.data;
        REG_FRONT_CH:  front_ch  <= cfg.data[CH_W-1:0];
        REG_LEFT_CH:   left_ch   <= cfg.data[CH_W-1:0];
        REG_RIGHT_CH:  right_ch  <= cfg.data[CH_W-1:0];
        default: ;
      endcase
    end
  end

  assign samples.ready      = (state == S_IDLE);
  assign results.valid      = res_valid;
  assign results.channel    = res_channel;
  assign results.distance   = res_distance;
  assign results.front_wall = res_front;
  assign results.left_wall  = res_left;
  assign results.right_wall = res_right;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      counter    <= '0;
      poly_start <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      poly_start <= 1'b0;
      if (res_valid && results.ready) res_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (samples.valid) begin
            x_q     <= samples.adc_sample[SAMPLE_BITS-1:0];
            cur_ch  <= counter;
            counter <= (counter == LAST_CH) ? '0 : counter + 1'b1;
            if (counter == '0) begin
              state <= S_ROM;
            end else begin
              poly_start <= 1'b1;
              state      <= S_POLY;
            end
          end
        end
        S_ROM: state <= S_WRITE;
        S_POLY: begin
          if (poly_done) state <= S_WRITE;
        end
        S_WRITE: begin
          dist_q <= new_dist;
          state  <= S_RD_FRONT;
        end
        S_RD_FRONT: state <= S_RD_LEFT;
        S_RD_LEFT: begin
          front_f <= ch_ok(front_ch) && (rd_q < front_thr);
          state   <= S_RD_RIGHT;
        end
        S_RD_RIGHT: begin
          left_f <= ch_ok(left_ch) && (rd_q < left_thr);
          state  <= S_OUT;
        end
        S_OUT: begin
          // hold until the output register is free
          if (!res_valid || results.ready) begin
            res_valid    <= 1'b1;
            res_channel  <= CH_W'(cur_ch);
            res_distance <= dist_q;
            res_front    <= front_f;
            res_left     <= left_f;
            res_right    <= ch_ok(right_ch) && (rd_q < right_thr);
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/ird_checker.sv =====
`timescale 1ns / 1ps

module ird_checker import ird_pkg::*; #(
  parameter int NUM_CHANNELS = 7
) (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [CH_W-1:0]   out_channel,
  input logic [DIST_W-1:0] out_distance
);

  localparam int CNT_W = $clog2(NUM_CHANNELS);
  localparam logic [CNT_W-1:0] LAST_CH = CNT_W'(NUM_CHANNELS - 1);

  logic [CNT_W-1:0] exp_ch;

  // expected round-robin channel of the next result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      exp_ch <= '0;
    end else if (out_valid && out_ready) begin
      exp_ch <= (exp_ch == LAST_CH) ? '0 : exp_ch + 1'b1;
    end
  end

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_distance) && $stable(out_channel))
    else $error("result beat changed while stalled");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("sample taken while a sample is in work");

  a_channel_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready |-> out_channel == CH_W'(exp_ch))
    else $error("result channel out of round-robin order");

  a_reset_empty: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !out_valid)
    else $error("result beat present straight after reset");

endmodule

bind ir_distance_linearizer ird_checker #(
  .NUM_CHANNELS (NUM_CHANNELS)
) u_ird_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (samples.valid),
  .in_ready     (samples.ready),
  .out_valid    (results.valid),
  .out_ready    (results.ready),
  .out_channel  (results.channel),
  .out_distance (results.distance)
);

// ===== dv/ir_distance_linearizer_tb.sv =====
`timescale 1ns / 1ps

import ird_pkg::*;

typedef struct {
  logic [CH_W-1:0]   channel;
  logic [DIST_W-1:0] distance;
  logic              front_wall;
  logic              left_wall;
  logic              right_wall;
} reading_t;

class dist_scoreboard;
  localparam int NUM_CH   = 7;
  localparam int ROM_BITS = 10;
  localparam longint unsigned LN2_Q30_C = 64'd744261118;

  // Quartic in 1/16 mm with 16 fraction bits, voltage folded into the coefficients
  localparam longint HC0 = (64'd160 * 64'd339 * 64'd65536 + 64'd5) / 64'd10;
  localparam longint HC1 = (64'd160 * 64'd695 * 64'd33 * 64'd65536 + 64'd50) / 64'd100;
  localparam longint HC2 =
    (64'd160 * 64'd623 * 64'd1089 * 64'd65536 + 64'd500) / 64'd1000;
  localparam longint HC3 =
    (64'd160 * 64'd254 * 64'd35937 * 64'd65536 + 64'd5000) / 64'd10000;
  localparam longint HC4 =
    (64'd160 * 64'd383 * 64'd1185921 * 64'd65536 + 64'd500000) / 64'd1000000;

  logic [DIST_W-1:0] front_thr, left_thr, right_thr;
  logic [CH_W-1:0]   front_ch, left_ch, right_ch;
  logic [CH_W-1:0]   next_ch;
  logic [DIST_W-1:0] last_dist [NUM_CH];
  reading_t          expected_readings [$];
  int                errors;

  function new();
    front_thr = THR_RESET;
    left_thr  = THR_RESET;
    right_thr = THR_RESET;
    front_ch  = FRONT_CH_RESET;
    left_ch   = LEFT_CH_RESET;
    right_ch  = RIGHT_CH_RESET;
    next_ch   = '0;
    foreach (last_dist[i]) last_dist[i] = '0;
    errors = 0;
  endfunction

  function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_FRONT_THR: front_thr = val;
      REG_LEFT_THR:  left_thr  = val;
      REG_RIGHT_THR: right_thr = val;
      REG_FRONT_CH:  front_ch  = val[CH_W-1:0];
      REG_LEFT_CH:   left_ch   = val[CH_W-1:0];
      REG_RIGHT_CH:  right_ch  = val[CH_W-1:0];
      default: ;
    endcase
  endfunction

  // Base-2 log in Q28; fraction bits by repeated squaring of a Q30 mantissa
  function longint lg2_q28(longint unsigned n);
    int unsigned p;
    longint unsigned mant;
    longint unsigned fr;
    p = 0;
    fr = 0;
    while (p < 30 && (n >> (p + 1)) != 0) p++;
    mant = n << (30 - p);
    for (int i = 0; i < 28; i++) begin
      mant = (mant * mant) >> 30;
      fr = fr << 1;
      if (mant >= (64'd1 << 31)) begin
        mant = mant >> 1;
        fr = fr | 64'd1;
      end
    end
    return longint'((64'(p) << 28) | fr);
  endfunction

  // 1932.8 * v^-1.058 taken at the middle of the bin
  function logic [DIST_W-1:0] power_law_distance(int unsigned bin);
    longint unsigned mid, f, t, term, sum, v;
    longint lg10, lv, y, z, k;
    int unsigned sh;
    mid  = 64'(bin) * 64'd2 + 64'd1;
    lg10 = lg2_q28(64'd10);
    lv   = lg2_q28(64'd33 * mid) - lg10 - (longint'(ROM_BITS + 1) <<< 28);
    y    = -(lv * 1058) / 1000;
    z    = lg2_q28(64'd19328) - lg10 + y;
    k    = z >>> 28;
    f    = 64'(z - (k <<< 28));
    t    = (f * LN2_Q30_C) >> 28;
    term = 64'd1 << 30;
    sum  = term;
    for (int i = 1; i <= 14; i++) begin
      term = ((term * t) >> 30) / 64'(i);
      sum  = sum + term;
    end
    if (k >= 16) return 16'hFFFF;
    if (k < -31) return 16'h0000;
    sh = 32'(30 - k);
    v = (sum + (64'd1 << (sh - 1))) >> sh;
    return (v > 64'd65535) ? 16'hFFFF : v[DIST_W-1:0];
  endfunction

  function logic [DIST_W-1:0] horner_distance(logic [SAMPLE_W-1:0] x);
    longint acc, xs;
    xs  = longint'(x);
    acc = HC4;
    acc = ((acc * xs) >>> 16) - HC3;
    acc = ((acc * xs) >>> 16) + HC2;
    acc = ((acc * xs) >>> 16) - HC1;
    acc = ((acc * xs) >>> 16) + HC0;
    acc = (acc + 32768) >>> 16;
    if (acc < 0) return 16'h0000;
    if (acc > 65535) return 16'hFFFF;
    return acc[DIST_W-1:0];
  endfunction

  // A channel number past the last sensor never flags a wall
  function logic wall(logic [CH_W-1:0] ch, logic [DIST_W-1:0] thr);
    if (ch >= NUM_CH) return 1'b0;
    return last_dist[ch] < thr;
  endfunction

  function void note_sample(logic [SAMPLE_W-1:0] x);
    reading_t want;
    logic [CH_W-1:0] ch;
    ch = (next_ch >= NUM_CH) ? '0 : next_ch;
    want.distance = (ch == 0) ? power_law_distance(x >> (SAMPLE_W - ROM_BITS))
                              : horner_distance(x);
    last_dist[ch] = want.distance;
    next_ch = (ch + 1 >= NUM_CH) ? '0 : ch + 1'b1;
    want.channel    = ch;
    want.front_wall = wall(front_ch, front_thr);
    want.left_wall  = wall(left_ch, left_thr);
    want.right_wall = wall(right_ch, right_thr);
    expected_readings.push_back(want);
  endfunction

  function void compare(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
    end
  endfunction

  function void check_result(reading_t got);
    reading_t want;
    if (expected_readings.size() == 0) begin
      errors++;
      $display("%0t: result beat with nothing expected, channel %0d distance %0d",
               $time, got.channel, got.distance);
      return;
    end
    want = expected_readings.pop_front();
    compare("channel", want.channel, got.channel);
    compare("distance", want.distance, got.distance);
    compare("front_wall", want.front_wall, got.front_wall);
    compare("left_wall", want.left_wall, got.left_wall);
    compare("right_wall", want.right_wall, got.right_wall);
  endfunction

  function int pending();
    return expected_readings.size();
  endfunction
endclass

module ir_distance_linearizer_tb;

  localparam logic [CFG_IDX_W-1:0] SPARE_REG_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] SPARE_REG_7 = 3'd7;
  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_CYCLES = 120;
  localparam int TAIL_CYCLES = 40;

  logic clk;
  logic rst;

  ird_sample_if sample_bus ();
  ird_result_if result_bus ();
  ird_cfg_if    cfg_bus ();

  ir_distance_linearizer dut (
    .clk     (clk),
    .rst     (rst),
    .samples (sample_bus),
    .results (result_bus),
    .cfg     (cfg_bus)
  );

  dist_scoreboard sb = new();

  int tx_idle = 0;
  int rx_idle = 0;
  int hold_ask = 0;
  int stall_cycles = 0;

  logic [SAMPLE_W-1:0] corner_samples [23] = '{
    16'h0000, 16'hFFFF, 16'h0001, 16'hFFFE, 16'h8000, 16'h7FFF, 16'hAAAA,
    16'hFFFF, 16'h0000, 16'h5555, 16'h0040, 16'h003F, 16'h4000, 16'hC000,
    16'h0040, 16'h1234, 16'h0800, 16'h2000, 16'h6000, 16'hE000, 16'h9C40,
    16'hFFBF, 16'h0100
  };

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hold valid high across back-to-back beats; only lower it for a gap
  task automatic send_sample(logic [SAMPLE_W-1:0] x);
    while ($urandom_range(99) < tx_idle) begin
      sample_bus.valid <= 1'b0;
      @(posedge clk);
    end
    sample_bus.valid      <= 1'b1;
    sample_bus.adc_sample <= x;
    do @(posedge clk); while (!sample_bus.ready);
    sb.note_sample(x);
  endtask

  task automatic drain();
    sample_bus.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    do @(posedge clk); while (!cfg_bus.ready);
    sb.set_reg(idx, val);
  endtask

  task automatic apply_settings(logic [DIST_W-1:0] thr_f, logic [DIST_W-1:0] thr_l,
                                logic [DIST_W-1:0] thr_r, logic [CH_W-1:0] ch_f,
                                logic [CH_W-1:0] ch_l, logic [CH_W-1:0] ch_r);
    write_cfg(REG_FRONT_THR, thr_f);
    write_cfg(REG_LEFT_THR, thr_l);
    write_cfg(REG_RIGHT_THR, thr_r);
    // Upper data bits of a channel register carry junk
    write_cfg(REG_FRONT_CH, {13'($urandom), ch_f});
    write_cfg(REG_LEFT_CH, {13'($urandom), ch_l});
    write_cfg(REG_RIGHT_CH, {13'($urandom), ch_r});
    write_cfg(SPARE_REG_6, 16'($urandom));
    write_cfg(SPARE_REG_7, 16'($urandom));
    cfg_bus.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_random(int count, int tx_pct, int rx_pct, bit with_hold);
    logic [SAMPLE_W-1:0] x;
    tx_idle = tx_pct;
    rx_idle = rx_pct;
    for (int i = 0; i < count; i++) begin
      if (with_hold && i == 20) hold_ask++;
      case ($urandom_range(7))
        0: x = '0;
        1: x = '1;
        2: x = 16'($urandom_range(255));
        3: x = {10'($urandom), ($urandom_range(1) != 0) ? 6'h3F : 6'h00};
        default: x = 16'($urandom);
      endcase
      send_sample(x);
    end
    drain();
  endtask

  initial begin : result_sink
    reading_t got;
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    result_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (result_bus.valid && result_bus.ready) begin
        got.channel    = result_bus.channel;
        got.distance   = result_bus.distance;
        got.front_wall = result_bus.front_wall;
        got.left_wall  = result_bus.left_wall;
        got.right_wall = result_bus.right_wall;
        sb.check_result(got);
      end
      if (hold_seen != hold_ask) begin
        hold_seen = hold_ask;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_bus.ready <= 1'b0;
      end else begin
        result_bus.ready <= ($urandom_range(99) >= rx_idle);
      end
    end
  end

  always @(posedge clk) begin
    if ((sample_bus.valid && sample_bus.ready) || (result_bus.valid && result_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles == STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    rst                   <= 1'b1;
    sample_bus.valid      <= 1'b0;
    sample_bus.adc_sample <= '0;
    cfg_bus.valid         <= 1'b0;
    cfg_bus.index         <= '0;
    cfg_bus.data          <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Reset settings; early flags read channels that have not converted yet
    foreach (corner_samples[i]) send_sample(corner_samples[i]);
    drain();

    apply_settings(16'h0000, 16'hFFFF, THR_RESET, 3'd7, 3'd6, 3'd0);
    run_random(150, 7, 85, 1'b0);

    apply_settings(16'hFFFF, 16'h0000, 16'($urandom_range(8000)), 3'd4, 3'd0, 3'd7);
    run_random(150, 85, 7, 1'b0);

    apply_settings(16'($urandom_range(12000)), 16'($urandom_range(12000)),
                   16'($urandom_range(12000)), 3'($urandom_range(7)),
                   3'($urandom_range(7)), 3'($urandom_range(7)));
    run_random(150, 0, 0, 1'b1);

    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
